>>> rtl/core/usb_nrzi_packet_serializer_assert.svh
// ----------------------------------------------------------------------------
// USB NRZI serializer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef USB_NRZI_PACKET_SERIALIZER_ASSERT_SVH
`define USB_NRZI_PACKET_SERIALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UNPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UNPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/unps_pkg.sv
// ----------------------------------------------------------------------------
// USB NRZI serializer package
// Word types, command and symbol codes, and CRC constants.
// ----------------------------------------------------------------------------
`default_nettype none

package unps_pkg;

    localparam int VALUE_W = 16;
    localparam int COUNT_W = 5;
    localparam int OP_W    = 3;
    localparam int RUN_W   = 3;
    localparam int CRC5_W  = 5;
    localparam int CRC16_W = 16;

    localparam logic [CRC5_W-1:0]  CRC5_POLY  = 5'h05;
    localparam logic [CRC5_W-1:0]  CRC5_INIT  = 5'h1f;
    localparam logic [CRC16_W-1:0] CRC16_POLY = 16'h8005;
    localparam logic [CRC16_W-1:0] CRC16_INIT = 16'hffff;
    localparam logic [RUN_W-1:0]   STUFF_RUN  = 3'd6;
    localparam logic [RUN_W-1:0]   RUN_FIVE   = 3'd5;

    typedef enum logic [OP_W-1:0] {
        OP_IDLE_J = 3'd0,
        OP_SYNC   = 3'd1,
        OP_DATA   = 3'd2,
        OP_CRC5   = 3'd3,
        OP_CRC16  = 3'd4,
        OP_EOP    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        SYM_J     = 3'd0,
        SYM_K     = 3'd1,
        SYM_SE0   = 3'd2,
        SYM_BIT   = 3'd3,
        SYM_STUFF = 3'd4
    } sym_kind_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] bit_count;
        logic               msb_first;
        logic               restart_crc;
    } cmd_word_t;

    typedef struct packed {
        logic line_dp;
        logic line_dm;
        logic last_symbol;
    } sym_word_t;

    typedef struct packed {
        logic      valid;
        sym_kind_t kind;
        logic      data_bit;
        logic      clr_run;
        logic      last;
    } sym_req_t;

    typedef struct packed {
        logic free;
        logic run_five;
        logic stuff_due;
    } line_stat_t;

    typedef struct packed {
        logic load;
        logic msb;
        logic step;
    } shift_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/unps_crc.sv
// ----------------------------------------------------------------------------
// USB NRZI serializer CRC unit
// Serial CRC5 and CRC16 registers fed one data bit per cycle while feed is high.
// ----------------------------------------------------------------------------
`default_nettype none

module unps_crc (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           restart,
    input  wire logic                           feed,
    input  wire logic                           data_bit,
    output logic [unps_pkg::CRC5_W-1:0]         crc5,
    output logic [unps_pkg::CRC16_W-1:0]        crc16
);

    import unps_pkg::*;

    logic [CRC5_W-1:0]  crc5_reg;
    logic [CRC5_W-1:0]  crc5_next;
    logic [CRC16_W-1:0] crc16_reg;
    logic [CRC16_W-1:0] crc16_next;

    always_comb
    begin
        crc5_next  = crc5_reg;
        crc16_next = crc16_reg;
        if (restart)
        begin
            crc5_next  = CRC5_INIT;
            crc16_next = CRC16_INIT;
        end
        else if (feed)
        begin
            crc5_next  = {crc5_reg[CRC5_W-2:0], 1'b0}
                         ^ ((data_bit ^ crc5_reg[CRC5_W-1]) ? CRC5_POLY : '0);
            crc16_next = {crc16_reg[CRC16_W-2:0], 1'b0}
                         ^ ((data_bit ^ crc16_reg[CRC16_W-1]) ? CRC16_POLY : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc5_reg  <= CRC5_INIT;
            crc16_reg <= CRC16_INIT;
        end
        else
        begin
            crc5_reg  <= crc5_next;
            crc16_reg <= crc16_next;
        end
    end

    assign crc5  = crc5_reg;
    assign crc16 = crc16_reg;

endmodule

`default_nettype wire

>>> rtl/core/unps_shift.sv
// ----------------------------------------------------------------------------
// USB NRZI serializer bit shifter
// Holds the bits of one command and hands them out one per step.
// ----------------------------------------------------------------------------
`default_nettype none

module unps_shift #(
    parameter int SR_W = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire unps_pkg::shift_ctl_t     ctl,
    input  wire logic [SR_W-1:0]          load_data,
    input  wire logic [$clog2(SR_W+1)-1:0] load_count,
    output logic                          data_bit,
    output logic [$clog2(SR_W+1)-1:0]     rem
);

    import unps_pkg::*;

    localparam int CNT_W = $clog2(SR_W + 1);
    localparam int IDX_W = $clog2(SR_W);

    logic [SR_W-1:0]  sr_reg;
    logic [SR_W-1:0]  sr_next;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;
    logic             msb_reg;
    logic             msb_next;
    logic [CNT_W-1:0] rem_m1;

    assign rem_m1 = rem_reg - CNT_W'(1);

    always_comb
    begin
        sr_next  = sr_reg;
        rem_next = rem_reg;
        msb_next = msb_reg;
        if (ctl.load)
        begin
            sr_next  = load_data;
            rem_next = load_count;
            msb_next = ctl.msb;
        end
        else if (ctl.step && (rem_reg != '0))
        begin
            rem_next = rem_m1;
            if (!msb_reg)
            begin
                sr_next = {1'b0, sr_reg[SR_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            msb_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            msb_reg <= msb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

    assign data_bit = msb_reg ? sr_reg[rem_m1[IDX_W-1:0]] : sr_reg[0];
    assign rem      = rem_reg;

endmodule

`default_nettype wire

>>> rtl/core/unps_line.sv
// ----------------------------------------------------------------------------
// USB NRZI serializer line encoder
// NRZI codes each symbol request, counts ones, and holds the output word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "usb_nrzi_packet_serializer_assert.svh"

module unps_line (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  j_on_dp,
    input  wire unps_pkg::sym_req_t    req,
    output unps_pkg::line_stat_t       stat,
    output logic                       sym_valid,
    input  wire logic                  sym_stall,
    output unps_pkg::sym_word_t        sym
);

    import unps_pkg::*;

    logic             line_j_reg;
    logic             line_j_next;
    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] run_next;
    logic             valid_reg;
    logic             valid_next;
    sym_word_t        word_reg;
    sym_word_t        word_next;
    logic             se0;

    always_comb
    begin
        line_j_next = line_j_reg;
        run_next    = run_reg;
        se0         = 1'b0;
        case (req.kind)
            SYM_J:
            begin
                line_j_next = 1'b1;
            end
            SYM_K:
            begin
                line_j_next = 1'b0;
            end
            SYM_SE0:
            begin
                se0 = 1'b1;
            end
            SYM_BIT:
            begin
                if (req.data_bit)
                begin
                    run_next = run_reg + RUN_W'(1);
                end
                else
                begin
                    line_j_next = !line_j_reg;
                    run_next    = '0;
                end
            end
            SYM_STUFF:
            begin
                line_j_next = !line_j_reg;
                run_next    = '0;
            end
            default:
            begin
                line_j_next = line_j_reg;
            end
        endcase
        if (req.clr_run)
        begin
            run_next = '0;
        end

        word_next.line_dp     = se0 ? 1'b0 : (line_j_next == j_on_dp);
        word_next.line_dm     = se0 ? 1'b0 : (line_j_next != j_on_dp);
        word_next.last_symbol = req.last;

        if (!req.valid)
        begin
            line_j_next = line_j_reg;
            run_next    = run_reg;
            word_next   = word_reg;
        end

        if (req.valid)
        begin
            valid_next = 1'b1;
        end
        else if (!sym_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_j_reg <= 1'b1;
            run_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            line_j_reg <= line_j_next;
            run_reg    <= run_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign stat.free      = !valid_reg || !sym_stall;
    assign stat.run_five  = (run_reg == RUN_FIVE);
    assign stat.stuff_due = (run_reg == STUFF_RUN);
    assign sym_valid      = valid_reg;
    assign sym            = word_reg;

    `UNPS_ASSERT_NOW(a_req_needs_room, req.valid, stat.free,
        "Symbol request while the output word is still held")
    `UNPS_ASSERT_NOW(a_run_bounded, 1'b1, run_reg <= STUFF_RUN,
        "Ones run went past the stuffing point")
    `UNPS_ASSERT_NEXT(a_held_word_stable, valid_reg && sym_stall,
        valid_reg && $stable(word_reg), "Stalled output word changed")

endmodule

`default_nettype wire

>>> rtl/core/usb_nrzi_packet_serializer.sv
// After acceptance the command's state requests its first symbol, which the line encoder
// registers in the output word. Within a command, one symbol per cycle while sym_stall is low;
// cmd_stall stays high until the last symbol of the command is requested.
// Commands that emit nothing (data with zero bit count, unknown op) keep the block idle.
// Reset (rst_n low, asynchronous): line at idle J, ones run zero, CRCs all ones,
// low speed selected, no word pending on the output.
// ----------------------------------------------------------------------------
// USB NRZI packet serializer
// Low/full-speed USB transmit encoder: idle J, SYNC, data, CRC5, CRC16 and EOP
// commands become NRZI line symbols with bit stuffing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "usb_nrzi_packet_serializer_assert.svh"

module usb_nrzi_packet_serializer #(
    parameter int MAX_BITS_PER_ITEM = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_data,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire unps_pkg::cmd_word_t  cmd,
    output logic                      sym_valid,
    input  wire logic                 sym_stall,
    output unps_pkg::sym_word_t       sym
);

    import unps_pkg::*;

    localparam int SR_W  = (MAX_BITS_PER_ITEM > VALUE_W) ? MAX_BITS_PER_ITEM : VALUE_W;
    localparam int CNT_W = $clog2(SR_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SYNC = 4'b0010,
        ST_EOP  = 4'b0100,
        ST_BITS = 4'b1000
    } state_t;

    state_t       state_reg;
    state_t       state_next;
    logic [2:0]   step_reg;
    logic [2:0]   step_next;
    logic         clr_reg;
    logic         clr_next;
    logic         feed_reg;
    logic         feed_next;
    logic         j_on_dp_reg;

    logic               cmd_accept;
    logic [CNT_W-1:0]   count_sat;
    shift_ctl_t         sh_ctl;
    logic [SR_W-1:0]    sh_data;
    logic [CNT_W-1:0]   sh_count;
    logic               sh_bit;
    logic [CNT_W-1:0]   sh_rem;
    sym_req_t           req;
    line_stat_t         stat;
    logic               crc_restart;
    logic               crc_feed;
    logic [CRC5_W-1:0]  crc5;
    logic [CRC16_W-1:0] crc16;

    assign cfg_ready  = 1'b1;
    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign count_sat  = (32'(cmd.bit_count) > MAX_BITS_PER_ITEM) ?
                        CNT_W'(MAX_BITS_PER_ITEM) : CNT_W'(cmd.bit_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_on_dp_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            j_on_dp_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        clr_next     = clr_reg;
        feed_next    = feed_reg;
        sh_ctl       = '0;
        sh_data      = SR_W'(cmd.value);
        sh_count     = count_sat;
        crc_restart  = 1'b0;
        crc_feed     = 1'b0;
        req          = '0;
        req.kind     = SYM_J;
        req.data_bit = sh_bit;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd.op)
                        OP_IDLE_J:
                        begin
                            state_next = ST_EOP;
                            step_next  = 3'd2;
                            clr_next   = 1'b0;
                        end
                        OP_SYNC:
                        begin
                            state_next = ST_SYNC;
                            step_next  = 3'd0;
                        end
                        OP_EOP:
                        begin
                            state_next = ST_EOP;
                            step_next  = 3'd0;
                            clr_next   = 1'b1;
                        end
                        OP_DATA:
                        begin
                            crc_restart = cmd.restart_crc;
                            if (count_sat != '0)
                            begin
                                sh_ctl.load = 1'b1;
                                sh_ctl.msb  = cmd.msb_first;
                                feed_next   = 1'b1;
                                state_next  = ST_BITS;
                            end
                        end
                        OP_CRC5:
                        begin
                            sh_ctl.load = 1'b1;
                            sh_ctl.msb  = 1'b1;
                            sh_data     = SR_W'(~crc5);
                            sh_count    = CNT_W'(CRC5_W);
                            feed_next   = 1'b0;
                            state_next  = ST_BITS;
                        end
                        OP_CRC16:
                        begin
                            sh_ctl.load = 1'b1;
                            sh_ctl.msb  = 1'b1;
                            sh_data     = SR_W'(~crc16);
                            sh_count    = CNT_W'(CRC16_W);
                            feed_next   = 1'b0;
                            state_next  = ST_BITS;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SYNC:
            begin
                if (stat.free)
                begin
                    req.valid   = 1'b1;
                    req.clr_run = 1'b1;
                    req.kind    = (!step_reg[0] || (step_reg == 3'd7)) ? SYM_K : SYM_J;
                    req.last    = (step_reg == 3'd7);
                    step_next   = step_reg + 3'd1;
                    if (req.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EOP:
            begin
                if (stat.free)
                begin
                    req.valid   = 1'b1;
                    req.clr_run = clr_reg;
                    req.kind    = (step_reg == 3'd2) ? SYM_J : SYM_SE0;
                    req.last    = (step_reg == 3'd2);
                    step_next   = step_reg + 3'd1;
                    if (req.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BITS:
            begin
                if (stat.free)
                begin
                    req.valid = 1'b1;
                    if (stat.stuff_due)
                    begin
                        req.kind = SYM_STUFF;
                        req.last = (sh_rem == '0);
                    end
                    else
                    begin
                        req.kind    = SYM_BIT;
                        req.last    = (sh_rem == CNT_W'(1)) && !(sh_bit && stat.run_five);
                        sh_ctl.step = 1'b1;
                        crc_feed    = feed_reg;
                    end
                    if (req.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
            clr_reg   <= 1'b0;
            feed_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            clr_reg   <= clr_next;
            feed_reg  <= feed_next;
        end
    end

    unps_crc u_crc (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (crc_restart),
        .feed     (crc_feed),
        .data_bit (sh_bit),
        .crc5     (crc5),
        .crc16    (crc16)
    );

    unps_shift #(
        .SR_W (SR_W)
    ) u_shift (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sh_ctl),
        .load_data  (sh_data),
        .load_count (sh_count),
        .data_bit   (sh_bit),
        .rem        (sh_rem)
    );

    unps_line u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .j_on_dp    (j_on_dp_reg),
        .req        (req),
        .stat       (stat),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .sym        (sym)
    );

    `UNPS_ASSERT_NOW(a_idle_no_stuff, state_reg == ST_IDLE, !stat.stuff_due,
        "Stuff bit left pending after a command finished")
    `UNPS_ASSERT_NOW(a_empty_means_stuff, (state_reg == ST_BITS) && (sh_rem == '0),
        stat.stuff_due, "Bit state with no bits left and no stuff pending")
    `UNPS_ASSERT_NEXT(a_last_ends_cmd, req.valid && req.last, state_reg == ST_IDLE,
        "Command still busy after its last symbol")

endmodule

`default_nettype wire

>>> test/usb_nrzi_packet_serializer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// USB NRZI packet serializer testbench
// Sends directed commands and then random packets (sync, data, CRC, EOP)
// with noise under several idle and stall patterns and both bus speeds.
// Every line symbol is checked against an internal encoder model.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_nrzi_packet_serializer_test;
    import unps_pkg::*;

    localparam int MAX_BITS      = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 100;

    class line_predictor;
        bit             j_on_dp;
        bit             line_is_j;
        bit [2:0]       ones_run;
        bit [4:0]       crc5;
        bit [15:0]      crc16;
        sym_word_t      pending_symbols[$];
        int             errors;

        function new();
            j_on_dp    = 1'b0;
            line_is_j  = 1'b1;
            ones_run   = '0;
            crc5       = CRC5_INIT;
            crc16      = CRC16_INIT;
            errors     = 0;
        endfunction

        function void push_symbol(bit dp, bit dm);
            sym_word_t w;
            w.line_dp     = dp;
            w.line_dm     = dm;
            w.last_symbol = 1'b0;
            pending_symbols.push_back(w);
        endfunction

        function void drive_line(bit want_j);
            line_is_j = want_j;
            if (j_on_dp)
                push_symbol(want_j, ~want_j);
            else
                push_symbol(~want_j, want_j);
        endfunction

        function void feed_crc(bit b);
            bit fb5;
            bit fb16;
            fb5   = b ^ crc5[4];
            fb16  = b ^ crc16[15];
            crc5  = {crc5[3:0], 1'b0} ^ (fb5 ? CRC5_POLY : 5'd0);
            crc16 = {crc16[14:0], 1'b0} ^ (fb16 ? CRC16_POLY : 16'd0);
        endfunction

        function void send_bit(bit b);
            if (!b)
            begin
                ones_run = '0;
                drive_line(!line_is_j);
            end
            else
            begin
                drive_line(line_is_j);
                ones_run = ones_run + 3'd1;
                if (ones_run >= STUFF_RUN)
                begin
                    drive_line(!line_is_j);
                    ones_run = '0;
                end
            end
        endfunction

        function void accept_command(cmd_word_t c);
            int        first;
            int        count;
            int        idx;
            sym_word_t w;
            first = pending_symbols.size();
            case (c.op)
                OP_IDLE_J: drive_line(1'b1);
                OP_SYNC:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        drive_line(1'b0);
                        drive_line(1'b1);
                    end
                    drive_line(1'b0);
                    drive_line(1'b0);
                    ones_run = '0;
                end
                OP_DATA:
                begin
                    if (c.restart_crc)
                    begin
                        crc5  = CRC5_INIT;
                        crc16 = CRC16_INIT;
                    end
                    count = (c.bit_count > MAX_BITS) ? MAX_BITS : c.bit_count;
                    for (int i = 0; i < count; i++)
                    begin
                        idx = c.msb_first ? (count - 1 - i) : i;
                        feed_crc(c.value[idx]);
                        send_bit(c.value[idx]);
                    end
                end
                OP_CRC5:
                    for (int i = 4; i >= 0; i--)
                        send_bit(~crc5[i]);
                OP_CRC16:
                    for (int i = 15; i >= 0; i--)
                        send_bit(~crc16[i]);
                OP_EOP:
                begin
                    push_symbol(1'b0, 1'b0);
                    push_symbol(1'b0, 1'b0);
                    drive_line(1'b1);
                    ones_run = '0;
                end
                default: ;
            endcase
            if (pending_symbols.size() > first)
            begin
                w = pending_symbols[pending_symbols.size() - 1];
                w.last_symbol = 1'b1;
                pending_symbols[pending_symbols.size() - 1] = w;
            end
        endfunction

        function void check_symbol(sym_word_t got);
            sym_word_t want;
            if (pending_symbols.size() == 0)
            begin
                $error("unexpected symbol dp=%0b dm=%0b last=%0b",
                       got.line_dp, got.line_dm, got.last_symbol);
                errors++;
                return;
            end
            want = pending_symbols.pop_front();
            if (got.line_dp !== want.line_dp)
            begin
                $error("line_dp: expected %0b, actual %0b", want.line_dp, got.line_dp);
                errors++;
            end
            if (got.line_dm !== want.line_dm)
            begin
                $error("line_dm: expected %0b, actual %0b", want.line_dm, got.line_dm);
                errors++;
            end
            if (got.last_symbol !== want.last_symbol)
            begin
                $error("last_symbol: expected %0b, actual %0b",
                       want.last_symbol, got.last_symbol);
                errors++;
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd       = '0;
    logic      sym_valid;
    logic      sym_stall = 1'b0;
    sym_word_t sym;

    line_predictor predictor = new();

    int   idle_pct    = 0;
    int   stall_pct   = 0;
    logic hold_kick   = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;
    int   cycle_count = 0;

    usb_nrzi_packet_serializer #(
        .MAX_BITS_PER_ITEM(MAX_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .sym_valid(sym_valid),
        .sym_stall(sym_stall),
        .sym(sym)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sym_valid && !sym_stall)
            predictor.check_symbol(sym);
        if (hold_kick != hold_seen)
        begin
            hold_seen = hold_kick;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            sym_stall <= 1'b1;
        end
        else
            sym_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    function automatic cmd_word_t make_cmd(logic [2:0] op, logic [15:0] value,
                                           logic [4:0] count, logic msb, logic restart);
        cmd_word_t c;
        c.op          = op;
        c.value       = value;
        c.bit_count   = count;
        c.msb_first   = msb;
        c.restart_crc = restart;
        return c;
    endfunction

    task automatic send_cmd(input cmd_word_t c);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        predictor.accept_command(c);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (predictor.pending_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_speed(input logic fs);
        cfg_valid <= 1'b1;
        cfg_data  <= fs;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        predictor.j_on_dp = fs;
    endtask

    task automatic directed_commands();
        send_cmd(make_cmd(OP_IDLE_J, 16'h0000, 5'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_SYNC, 16'hffff, 5'd31, 1'b1, 1'b1));
        send_cmd(make_cmd(OP_DATA, 16'h00a5, 5'd8, 1'b0, 1'b1));
        send_cmd(make_cmd(OP_DATA, 16'hffff, 5'd16, 1'b1, 1'b0));
        send_cmd(make_cmd(OP_DATA, 16'h0000, 5'd16, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_DATA, 16'h8001, 5'd1, 1'b1, 1'b0));
        send_cmd(make_cmd(OP_DATA, 16'h1234, 5'd0, 1'b0, 1'b1));
        send_cmd(make_cmd(OP_DATA, 16'hffff, 5'd31, 1'b1, 1'b0));
        send_cmd(make_cmd(OP_DATA, 16'h5a5a, 5'd17, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_CRC5, 16'hffff, 5'd16, 1'b1, 1'b1));
        send_cmd(make_cmd(OP_CRC16, 16'h0000, 5'd0, 1'b0, 1'b1));
        send_cmd(make_cmd(OP_EOP, 16'hffff, 5'd31, 1'b1, 1'b0));
        send_cmd(make_cmd(3'd6, 16'hffff, 5'd16, 1'b1, 1'b1));
        send_cmd(make_cmd(3'd7, 16'h0000, 5'd8, 1'b0, 1'b1));
        send_cmd(make_cmd(OP_SYNC, 16'h0000, 5'd0, 1'b0, 1'b1));
        send_cmd(make_cmd(OP_DATA, 16'h003f, 5'd7, 1'b0, 1'b1));
        send_cmd(make_cmd(OP_DATA, 16'h0001, 5'd5, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_CRC16, 16'h0000, 5'd0, 1'b0, 1'b0));
        send_cmd(make_cmd(OP_EOP, 16'h0000, 5'd0, 1'b0, 1'b1));
        send_cmd(make_cmd(OP_IDLE_J, 16'hffff, 5'd31, 1'b1, 1'b1));
    endtask

    function automatic logic [15:0] data_value();
        return ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom);
    endfunction

    function automatic logic [4:0] data_count();
        return ($urandom_range(2) == 0) ? 5'($urandom_range(1, MAX_BITS)) : 5'd8;
    endfunction

    task automatic random_commands(input int target);
        int        counted;
        int        pick;
        int        n_data;
        cmd_word_t c;
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                send_cmd(make_cmd(OP_SYNC, 16'($urandom), 5'($urandom), 1'($urandom),
                                  1'($urandom)));
                n_data = $urandom_range(1, 4);
                for (int i = 0; i < n_data; i++)
                    send_cmd(make_cmd(OP_DATA, data_value(), data_count(), 1'($urandom),
                                      (i == 0) ? 1'b1 : 1'($urandom_range(9) == 0)));
                send_cmd(make_cmd($urandom_range(1) ? OP_CRC5 : OP_CRC16, 16'($urandom),
                                  5'($urandom), 1'($urandom), 1'($urandom)));
                send_cmd(make_cmd(OP_EOP, 16'($urandom), 5'($urandom), 1'($urandom),
                                  1'($urandom)));
                counted += n_data + 3;
            end
            else if (pick < 80)
            begin
                send_cmd(make_cmd(OP_IDLE_J, 16'($urandom), 5'($urandom), 1'($urandom),
                                  1'($urandom)));
                counted++;
            end
            else
            begin
                c = make_cmd(3'($urandom_range(7)), 16'($urandom), 5'($urandom_range(31)),
                             1'($urandom), 1'($urandom));
                send_cmd(c);
                if (c.op <= OP_EOP && !(c.op == OP_DATA && c.bit_count == 5'd0))
                    counted++;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_commands();
        drain();

        write_speed(1'b1);
        hold_kick <= ~hold_kick;
        random_commands(PHASE_ITEMS);
        drain();

        write_speed(1'b0);
        idle_pct = 88;
        random_commands(PHASE_ITEMS);
        drain();

        write_speed(1'b1);
        idle_pct = 0;
        stall_pct <= 88;
        random_commands(PHASE_ITEMS);
        drain();

        write_speed(1'b0);
        idle_pct = 23;
        stall_pct <= 23;
        random_commands(PHASE_ITEMS);
        drain();
        repeat (20) @(posedge clk);

        if (predictor.errors == 0 && predictor.pending_symbols.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> usb_nrzi_packet_serializer.f
+incdir+rtl/core
rtl/core/unps_pkg.sv
rtl/core/unps_crc.sv
rtl/core/unps_shift.sv
rtl/core/unps_line.sv
rtl/core/usb_nrzi_packet_serializer.sv
test/usb_nrzi_packet_serializer_test.sv
